// ===== rtl/bts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Beat payload types, field widths and named codes shared by the sampler
// and its stream interfaces.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int CH_W      = 16;
   localparam int COORD_W   = 20;
   localparam int TIDX_W    = 12;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int FRAC_W    = 16;
   localparam int PX_W      = 27;
   localparam int INT_W     = PX_W - FRAC_W;
   localparam int SUM_W     = 20;
   localparam int AREA_W    = 2 * CFG_W;
   localparam int PROD_W    = 33;
   localparam int NCH       = 4;
   localparam int NNB       = 4;
   localparam int NSTG      = 8;
   localparam int RD_STG    = 4;
   localparam int WIDE_W    = 17;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   typedef logic [CH_W-1:0] chan_type;

   typedef struct packed {
      logic                      kind;
      logic [TIDX_W-1:0]         texel_index;
      chan_type                  in_red;
      chan_type                  in_green;
      chan_type                  in_blue;
      chan_type                  in_alpha;
      logic signed [COORD_W-1:0] coord_u;
      logic signed [COORD_W-1:0] coord_v;
   } req_payload_type;

   typedef struct packed {
      chan_type out_red;
      chan_type out_green;
      chan_type out_blue;
      chan_type out_alpha;
   } rsp_payload_type;

endpackage

// ===== rtl/bts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler stream interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bts_req_if;
   import bts_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// Path: samples pass stage registers to the result channel; a write yields no result.
// Throughput: one beat per cycle, writes and samples mixed, while results are taken.
// The rate is set by the eight-stage pipeline and the two dual-read copies of the store.
// Reset: valid bits clear, width and height return to 64; the store is not cleared
// and holds nothing defined until written.
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// Texel store loaded by write beats; sample beats scale u and v, clamp the
// four neighbour indices, read the store and blend horizontally then
// vertically.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
   parameter int STORE_DEPTH  = 4096,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bts_pkg::CFG_W-1:0]      csr_wr_data,
   bts_req_if.sink                        req_bus,
   bts_rsp_if.source                      rsp_bus
);
   import bts_pkg::*;

   localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LIM_W = $clog2(STORE_DEPTH + 1);
   localparam int TEX_W = NCH * CHANNEL_BITS;

   // configuration
   logic [CFG_W-1:0]  tex_width_ff, tex_height_ff;
   logic [CFG_W-1:0]  w_eff, h_eff;
   logic signed [CFG_W:0] w_s;
   logic [AREA_W-1:0] area;
   logic [LIM_W-1:0]  limit_in, limit_ff;

   // pipeline control
   logic [NSTG:1] vld_ff, vld_in, en;

   // stage registers
   logic                      s1_kind_ff, s2_kind_ff, s3_kind_ff;
   logic [TIDX_W-1:0]         s1_tidx_ff, s2_tidx_ff, s3_tidx_ff;
   logic [TEX_W-1:0]          s1_texel_in, s1_texel_ff, s2_texel_ff, s3_texel_ff;
   logic signed [COORD_W-1:0] s1_u_ff, s1_v_ff;
   logic signed [PX_W-1:0]    s2_px_in, s2_py_in, s2_px_ff, s2_py_ff;
   logic signed [INT_W-1:0]   x0, y0;
   logic signed [SUM_W-1:0]   s3_base_in, s3_base_ff;
   logic [FRAC_W-1:0]         s3_fx_ff, s3_fy_ff, s4_fx_ff, s4_fy_ff, s5_fy_ff, s6_fy_ff;
   logic signed [SUM_W-1:0]   nb [NNB];
   logic [AW-1:0]             rd_addr [NNB];
   logic [WIDE_W-1:0]         wr_wide;
   logic [AW-1:0]             wr_addr;
   logic                      wr_in_range, mem_we;
   logic [TEX_W-1:0]          s4_tex_ff [NNB];
   chan_type                  s5_base_in [2][NCH];
   chan_type                  s5_base_ff [2][NCH];
   logic [PROD_W-1:0]         s5_prod_in [2][NCH];
   logic [PROD_W-1:0]         s5_prod_ff [2][NCH];
   chan_type                  s6_lerp_in [2][NCH];
   chan_type                  s6_lerp_ff [2][NCH];
   logic [PROD_W-1:0]         s7_prod_in [NCH];
   logic [PROD_W-1:0]         s7_prod_ff [NCH];
   chan_type                  s7_top_ff [NCH];
   chan_type                  s8_res_in [NCH];
   chan_type                  s8_res_ff [NCH];

   // memories: two copies, each read at two addresses
   logic [TEX_W-1:0] mem_a [STORE_DEPTH];
   logic [TEX_W-1:0] mem_b [STORE_DEPTH];

   function automatic logic [AW-1:0] clamp_addr(input logic signed [SUM_W-1:0] idx,
                                                 input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] top_idx;
      logic [SUM_W-1:0] mag;
      top_idx = lim - LIM_W'(1);
      mag     = idx;
      if (idx < 0) begin
         clamp_addr = '0;
      end else if (mag >= SUM_W'(lim)) begin
         clamp_addr = top_idx[AW-1:0];
      end else begin
         clamp_addr = mag[AW-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= SIZE_RESET;
         tex_height_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TEX_WIDTH:  tex_width_ff  <= csr_wr_data;
            REG_TEX_HEIGHT: tex_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign w_eff = (tex_width_ff == '0) ? CFG_W'(1) : tex_width_ff;
   assign h_eff = (tex_height_ff == '0) ? CFG_W'(1) : tex_height_ff;
   assign w_s   = {1'b0, w_eff};
   assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);
   assign limit_in = (WIDE_W'(area) > WIDE_W'(STORE_DEPTH)) ? LIM_W'(STORE_DEPTH)
                                                            : LIM_W'(area);

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   // handshake chain
   always_comb begin
      en[NSTG] = !vld_ff[NSTG] || rsp_bus.ready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = en[1] ? req_bus.valid : vld_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1] && ((k != RD_STG) || (s3_kind_ff == KIND_SAMPLE));
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = en[1];

   // stage 1: capture beat
   assign s1_texel_in = {req_bus.payload.in_alpha[CHANNEL_BITS-1:0],
                         req_bus.payload.in_blue[CHANNEL_BITS-1:0],
                         req_bus.payload.in_green[CHANNEL_BITS-1:0],
                         req_bus.payload.in_red[CHANNEL_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_kind_ff  <= req_bus.payload.kind;
         s1_tidx_ff  <= req_bus.payload.texel_index;
         s1_texel_ff <= s1_texel_in;
         s1_u_ff     <= req_bus.payload.coord_u;
         s1_v_ff     <= req_bus.payload.coord_v;
      end
   end

   // stage 2: scale coordinates
   assign s2_px_in = PX_W'(w_s) * PX_W'(s1_u_ff);
   assign s2_py_in = PX_W'(signed'({1'b0, h_eff})) * PX_W'(s1_v_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_tidx_ff  <= s1_tidx_ff;
         s2_texel_ff <= s1_texel_ff;
         s2_px_ff    <= s2_px_in;
         s2_py_ff    <= s2_py_in;
      end
   end

   // stage 3: linear index of the top-left neighbour
   assign x0 = s2_px_ff[PX_W-1:FRAC_W];
   assign y0 = s2_py_ff[PX_W-1:FRAC_W];
   assign s3_base_in = SUM_W'(x0) + SUM_W'(w_s) * SUM_W'(y0);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_tidx_ff  <= s2_tidx_ff;
         s3_texel_ff <= s2_texel_ff;
         s3_base_ff  <= s3_base_in;
         s3_fx_ff    <= s2_px_ff[FRAC_W-1:0];
         s3_fy_ff    <= s2_py_ff[FRAC_W-1:0];
      end
   end

   // stage 4: clamp neighbours, write or read the store
   always_comb begin
      nb[0] = s3_base_ff;
      nb[1] = s3_base_ff + SUM_W'(1);
      nb[2] = s3_base_ff + SUM_W'(w_s);
      nb[3] = s3_base_ff + SUM_W'(w_s) + SUM_W'(1);
      for (int n = 0; n < NNB; n++) begin
         rd_addr[n] = clamp_addr(nb[n], limit_ff);
      end
   end

   assign wr_wide     = WIDE_W'(s3_tidx_ff);
   assign wr_in_range = wr_wide < WIDE_W'(STORE_DEPTH);
   assign wr_addr     = wr_wide[AW-1:0];
   assign mem_we      = vld_ff[3] && (s3_kind_ff == KIND_WRITE) && en[RD_STG] && wr_in_range;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_a[wr_addr] <= s3_texel_ff;
         mem_b[wr_addr] <= s3_texel_ff;
      end
      if (en[RD_STG]) begin
         s4_tex_ff[0] <= mem_a[rd_addr[0]];
         s4_tex_ff[1] <= mem_a[rd_addr[1]];
         s4_tex_ff[2] <= mem_b[rd_addr[2]];
         s4_tex_ff[3] <= mem_b[rd_addr[3]];
         s4_fx_ff     <= s3_fx_ff;
         s4_fy_ff     <= s3_fy_ff;
      end
   end

   // stage 5: horizontal products, top and bottom rows
   always_comb begin
      chan_type              bv;
      logic signed [CH_W:0]  diff;
      for (int j = 0; j < 2; j++) begin
         for (int c = 0; c < NCH; c++) begin
            s5_base_in[j][c] = chan_type'(s4_tex_ff[2*j][c*CHANNEL_BITS +: CHANNEL_BITS]);
            bv   = chan_type'(s4_tex_ff[2*j+1][c*CHANNEL_BITS +: CHANNEL_BITS]);
            diff = signed'({1'b0, bv}) - signed'({1'b0, s5_base_in[j][c]});
            s5_prod_in[j][c] = PROD_W'(diff) * PROD_W'(signed'({1'b0, s4_fx_ff}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_base_ff <= s5_base_in;
         s5_prod_ff <= s5_prod_in;
         s5_fy_ff   <= s4_fy_ff;
      end
   end

   // stage 6: horizontal blend
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         for (int c = 0; c < NCH; c++) begin
            s6_lerp_in[j][c] = chan_type'({1'b0, s5_base_ff[j][c]}
                                          + s5_prod_ff[j][c][PROD_W-1:FRAC_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_lerp_ff <= s6_lerp_in;
         s6_fy_ff   <= s5_fy_ff;
      end
   end

   // stage 7: vertical products
   always_comb begin
      logic signed [CH_W:0] diff;
      for (int c = 0; c < NCH; c++) begin
         diff = signed'({1'b0, s6_lerp_ff[1][c]}) - signed'({1'b0, s6_lerp_ff[0][c]});
         s7_prod_in[c] = PROD_W'(diff) * PROD_W'(signed'({1'b0, s6_fy_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_prod_ff <= s7_prod_in;
         s7_top_ff  <= s6_lerp_ff[0];
      end
   end

   // stage 8: vertical blend into the result register
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         s8_res_in[c] = chan_type'({1'b0, s7_top_ff[c]} + s7_prod_ff[c][PROD_W-1:FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_res_ff <= s8_res_in;
      end
   end

   assign rsp_bus.valid             = vld_ff[NSTG];
   assign rsp_bus.payload.out_red   = s8_res_ff[0];
   assign rsp_bus.payload.out_green = s8_res_ff[1];
   assign rsp_bus.payload.out_blue  = s8_res_ff[2];
   assign rsp_bus.payload.out_alpha = s8_res_ff[3];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> vld_ff[1])
      else $error("accepted beat missing from first stage");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && (s3_kind_ff == KIND_WRITE) && en[RD_STG] |=> !vld_ff[RD_STG])
      else $error("write beat passed the store stage");

   a_addr_in_limit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && (s3_kind_ff == KIND_SAMPLE) |->
         (LIM_W'(rd_addr[0]) < limit_ff) && (LIM_W'(rd_addr[1]) < limit_ff) &&
         (LIM_W'(rd_addr[2]) < limit_ff) && (LIM_W'(rd_addr[3]) < limit_ff))
      else $error("neighbour address beyond texture");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] && !en[7] |=> vld_ff[6] && $stable(s6_fy_ff))
      else $error("stalled blend stage lost its beat");

endmodule
